FILE: rtl/vpr_pkg.sv
package vpr_pkg;

   // Fixed-point format of the trig values and result fields
   localparam int FRAC_BITS = 15;
   localparam int FIELD_W   = 16;

   // Angles in tenths of a degree
   localparam int QUARTER     = 900;
   localparam int FULL_TURN   = 3600;
   localparam int LIMIT_MAX   = 899;
   localparam int LIMIT_RESET = 450;
   localparam int IDX_W       = 10;

   // Yaw wrap: bias keeps the sum positive, reciprocal replaces the modulo
   localparam int WRAP_BIAS  = FULL_TURN * 19;
   localparam int WRAP_SHIFT = 23;
   localparam int WRAP_RECIP = (1 << WRAP_SHIFT) / FULL_TURN;

   typedef logic [FRAC_BITS-1:0] trig_mag_type;
   typedef trig_mag_type sin_table_type [0:QUARTER];

   // Updated yaw and pitch handed from the angle stage
   typedef struct packed {
      logic        [11:0] yaw;
      logic signed [10:0] pitch;
   } angle_type;

   // Table magnitudes and signs handed from the lookup stage
   typedef struct packed {
      trig_mag_type sy;
      trig_mag_type cy;
      trig_mag_type sp;
      trig_mag_type cp;
      logic         sy_neg;
      logic         cy_neg;
      logic         sp_neg;
   } trig_type;

   // Sine of t tenths of a degree (t in 0..900), Taylor series in Q30
   function automatic trig_mag_type quarter_sin(input int t);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned prod;
      longint          sum;
      longint          q;
      longint          maxq;
      x = (64'(unsigned'(t)) * 64'd3373259426 + 64'd900) / 64'd1800;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      maxq = (longint'(1) << FRAC_BITS) - 1;
      for (int k = 1; k <= 9; k++) begin
         prod = (term * x2) >> 30;
         unique case (k)
            1:       term = prod / 64'd6;
            2:       term = prod / 64'd20;
            3:       term = prod / 64'd42;
            4:       term = prod / 64'd72;
            5:       term = prod / 64'd110;
            6:       term = prod / 64'd156;
            7:       term = prod / 64'd210;
            8:       term = prod / 64'd272;
            default: term = prod / 64'd342;
         endcase
         if (k % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (FRAC_BITS < 30) begin
         q = (sum + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      end else if (FRAC_BITS == 30) begin
         q = sum;
      end else begin
         q = sum << (FRAC_BITS - 30);
      end
      if (q > maxq) begin
         q = maxq;
      end
      return trig_mag_type'(q);
   endfunction

   // Quarter-wave table contents
   function automatic sin_table_type build_sin_table();
      sin_table_type tbl;
      for (int i = 0; i <= QUARTER; i++) begin
         tbl[i] = quarter_sin(i);
      end
      return tbl;
   endfunction

   // Apply a sign to a magnitude and keep the low field bits
   function automatic logic [FIELD_W-1:0] to_field(input logic neg, input trig_mag_type mag);
      logic [FRAC_BITS+FIELD_W:0] wide;
      wide = {{(FIELD_W+1){1'b0}}, mag};
      if (neg) begin
         wide = -wide;
      end
      return wide[FIELD_W-1:0];
   endfunction

endpackage

FILE: rtl/vpr_angle.sv
module vpr_angle (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic signed [15:0]      mouse_x,
   input  logic signed [15:0]      mouse_y,
   input  logic                    csr_wr_en,
   input  logic [9:0]              csr_wr_data,
   output vpr_pkg::angle_type      angle
);

   logic        [11:0] yaw_ff, yaw_in;
   logic signed [10:0] pitch_ff, pitch_in;
   logic signed [15:0] last_x_ff, last_y_ff;
   logic        [9:0]  limit_ff;

   logic signed [16:0] dx, dy;
   logic signed [18:0] wrap_sum;
   logic        [17:0] wrap_u;
   logic        [29:0] recip_prod;
   logic        [6:0]  quot_est;
   logic        [17:0] wrap_rem;
   logic signed [17:0] pitch_sum;
   logic        [9:0]  lim;
   logic signed [17:0] lim_s;

   // Movement since the previous pointer position
   assign dx = 17'(mouse_x) - 17'(last_x_ff);
   assign dy = 17'(mouse_y) - 17'(last_y_ff);

   // Yaw modulo a full turn: biased sum, reciprocal quotient, one correction
   assign wrap_sum   = signed'(19'(yaw_ff)) + 19'(dx) + 19'(vpr_pkg::WRAP_BIAS);
   assign wrap_u     = wrap_sum[17:0];
   assign recip_prod = 30'(wrap_u) * 30'(vpr_pkg::WRAP_RECIP);
   assign quot_est   = recip_prod[29:vpr_pkg::WRAP_SHIFT];
   assign wrap_rem   = wrap_u - 18'(quot_est) * 18'(vpr_pkg::FULL_TURN);

   always_comb begin
      if (wrap_rem >= 18'(vpr_pkg::FULL_TURN)) begin
         yaw_in = 12'(wrap_rem - 18'(vpr_pkg::FULL_TURN));
      end else begin
         yaw_in = wrap_rem[11:0];
      end
   end

   // Pitch saturates at the programmed limit, itself held below a right angle
   assign pitch_sum = 18'(pitch_ff) + 18'(dy);
   assign lim       = (limit_ff > 10'(vpr_pkg::LIMIT_MAX)) ? 10'(vpr_pkg::LIMIT_MAX) : limit_ff;
   assign lim_s     = signed'({8'b0, lim});

   always_comb begin
      priority if (pitch_sum > lim_s) begin
         pitch_in = 11'(lim_s);
      end else if (pitch_sum < -lim_s) begin
         pitch_in = 11'(-lim_s);
      end else begin
         pitch_in = 11'(pitch_sum);
      end
   end

   // Hold state between accepted words
   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff    <= '0;
         pitch_ff  <= '0;
         last_x_ff <= '0;
         last_y_ff <= '0;
         limit_ff  <= 10'(vpr_pkg::LIMIT_RESET);
      end else begin
         if (accept) begin
            yaw_ff    <= yaw_in;
            pitch_ff  <= pitch_in;
            last_x_ff <= mouse_x;
            last_y_ff <= mouse_y;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   assign angle.yaw   = yaw_ff;
   assign angle.pitch = pitch_ff;

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      yaw_ff < 12'(vpr_pkg::FULL_TURN))
      else $error("yaw left the full turn");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      (pitch_ff <= 11'sd899) && (pitch_ff >= -11'sd899))
      else $error("pitch passed a right angle");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(yaw_ff) && $stable(pitch_ff) && $stable(last_x_ff))
      else $error("angle state moved without a word");

endmodule

FILE: rtl/vpr_sin_rom.sv
module vpr_sin_rom (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [vpr_pkg::IDX_W-1:0]       addr_a,
   input  logic [vpr_pkg::IDX_W-1:0]       addr_b,
   output vpr_pkg::trig_mag_type           data_a,
   output vpr_pkg::trig_mag_type           data_b
);

   localparam vpr_pkg::sin_table_type ROM_DATA = vpr_pkg::build_sin_table();

   vpr_pkg::trig_mag_type data_a_ff, data_b_ff;

   // Two registered read ports, held while the stage stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= ROM_DATA[addr_a];
         data_b_ff <= ROM_DATA[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

FILE: rtl/vpr_trig.sv
module vpr_trig (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  vpr_pkg::angle_type  angle,
   output logic                out_valid,
   output vpr_pkg::trig_type   trig
);

   logic [1:0]                   quad;
   logic [11:0]                  quad_base;
   logic [vpr_pkg::IDX_W-1:0]    rem, rev;
   logic [vpr_pkg::IDX_W-1:0]    sy_addr, cy_addr, sp_addr, cp_addr;
   logic                         valid_ff;
   logic                         sy_neg_ff, cy_neg_ff, sp_neg_ff;

   // Split yaw into quadrant and offset within the quadrant
   always_comb begin
      priority if (angle.yaw >= 12'(3 * vpr_pkg::QUARTER)) begin
         quad = 2'd3;
      end else if (angle.yaw >= 12'(2 * vpr_pkg::QUARTER)) begin
         quad = 2'd2;
      end else if (angle.yaw >= 12'(vpr_pkg::QUARTER)) begin
         quad = 2'd1;
      end else begin
         quad = 2'd0;
      end
   end

   always_comb begin
      unique case (quad)
         2'd0: quad_base = 12'd0;
         2'd1: quad_base = 12'(vpr_pkg::QUARTER);
         2'd2: quad_base = 12'(2 * vpr_pkg::QUARTER);
         default: quad_base = 12'(3 * vpr_pkg::QUARTER);
      endcase
   end

   assign rem = vpr_pkg::IDX_W'(angle.yaw - quad_base);
   assign rev = vpr_pkg::IDX_W'(vpr_pkg::QUARTER) - rem;

   // Odd quadrants mirror the quarter wave; cosine is the sine a quadrant on
   assign sy_addr = quad[0] ? rev : rem;
   assign cy_addr = quad[0] ? rem : rev;

   // Pitch stays inside a quarter, so only its magnitude is looked up
   assign sp_addr = angle.pitch[10] ? vpr_pkg::IDX_W'(-angle.pitch)
                                    : vpr_pkg::IDX_W'(angle.pitch);
   assign cp_addr = vpr_pkg::IDX_W'(vpr_pkg::QUARTER) - sp_addr;

   vpr_sin_rom u_yaw_rom (
      .clock  (clock),
      .rd_en  (en),
      .addr_a (sy_addr),
      .addr_b (cy_addr),
      .data_a (trig.sy),
      .data_b (trig.cy)
   );

   vpr_sin_rom u_pitch_rom (
      .clock  (clock),
      .rd_en  (en),
      .addr_a (sp_addr),
      .addr_b (cp_addr),
      .data_a (trig.sp),
      .data_b (trig.cp)
   );

   // Signs travel beside the table reads
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sy_neg_ff <= quad[1];
         cy_neg_ff <= quad[1] ^ quad[0];
         sp_neg_ff <= angle.pitch[10];
      end
   end

   assign trig.sy_neg = sy_neg_ff;
   assign trig.cy_neg = cy_neg_ff;
   assign trig.sp_neg = sp_neg_ff;
   assign out_valid   = valid_ff;

endmodule

FILE: rtl/vpr_product.sv
module vpr_product (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  vpr_pkg::trig_type   trig,
   output logic                out_valid,
   output logic [127:0]        out_data
);

   localparam int PW = 2 * vpr_pkg::FRAC_BITS + 1;

   vpr_pkg::trig_mag_type mag_sp_cy, mag_sp_sy, mag_cp_cy, mag_sy_cp;
   logic [127:0]          data_in;
   logic [127:0]          data_ff;
   logic                  valid_ff;

   // Q product of two magnitudes, rounded half up (half away from zero overall)
   function automatic vpr_pkg::trig_mag_type qmul_mag(input vpr_pkg::trig_mag_type a,
                                                      input vpr_pkg::trig_mag_type b);
      logic [PW-1:0] p;
      p = PW'(a) * PW'(b) + (PW'(1) << (vpr_pkg::FRAC_BITS - 1));
      return p[2*vpr_pkg::FRAC_BITS-1:vpr_pkg::FRAC_BITS];
   endfunction

   assign mag_sp_cy = qmul_mag(trig.sp, trig.cy);
   assign mag_sp_sy = qmul_mag(trig.sp, trig.sy);
   assign mag_cp_cy = qmul_mag(trig.cp, trig.cy);
   assign mag_sy_cp = qmul_mag(trig.sy, trig.cp);

   // Pack the eight matrix entries, right_x in the lowest bits
   assign data_in = {
      vpr_pkg::to_field(!trig.sy_neg, mag_sy_cp),
      vpr_pkg::to_field(!trig.sp_neg, trig.sp),
      vpr_pkg::to_field(!trig.cy_neg, mag_cp_cy),
      vpr_pkg::to_field(trig.sp_neg ^ trig.sy_neg, mag_sp_sy),
      vpr_pkg::to_field(1'b1, trig.cp),
      vpr_pkg::to_field(trig.sp_neg ^ trig.cy_neg, mag_sp_cy),
      vpr_pkg::to_field(trig.cy_neg, trig.cy),
      vpr_pkg::to_field(!trig.sy_neg, trig.sy)
   };

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/yaw_pitch_view_rotation.sv
// Channel  | Direction | Word
// req_     | in        | tdata: mouse_x[15:0], mouse_y[31:16]
// rsp_     | out       | tdata: right_x, right_z, up_x, up_y, up_z, back_x, back_y, back_z
// csr_     | in        | wr_data: pitch_limit[9:0], written when wr_en is high
//
// One word per cycle unless a stalled result has filled every stage; a result is presented once
// its word has passed the angle update at the edge that takes it, then the registered quarter-wave
// table read, then the products into the result register.
// Yaw wrap and pitch clamp are combinational in the angle stage, so words follow back to back.
// Reset clears yaw, pitch and last position to zero and sets the pitch limit to 450.
// Each stage advances while the stage after it is empty or moving, so a stalled result
// still lets words fill the stages behind it.
module yaw_pitch_view_rotation (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // mouse_x, mouse_y
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // right_x, right_z, up_x, up_y, up_z, back_x, back_y, back_z
   input  logic         csr_wr_en,
   input  logic [9:0]   csr_wr_data
);

   vpr_pkg::angle_type angle;
   vpr_pkg::trig_type  trig;
   logic               s1_valid_ff;
   logic               s2_valid;
   logic               out_en, s2_en, s1_en;
   logic               accept;

   // Per-stage advance, from the result register back to the input
   assign out_en     = !rsp_tvalid || rsp_tready;
   assign s2_en      = !s2_valid || out_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;
   assign accept     = req_tvalid && s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   vpr_angle u_angle (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mouse_x     (signed'(req_tdata[15:0])),
      .mouse_y     (signed'(req_tdata[31:16])),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .angle       (angle)
   );

   vpr_trig u_trig (
      .clock     (clock),
      .reset     (reset),
      .en        (s2_en),
      .in_valid  (s1_valid_ff),
      .angle     (angle),
      .out_valid (s2_valid),
      .trig      (trig)
   );

   vpr_product u_product (
      .clock     (clock),
      .reset     (reset),
      .en        (out_en),
      .in_valid  (s2_valid),
      .trig      (trig),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_en |=> s1_valid_ff && $stable(angle))
      else $error("angle stage overwritten while stalled");

   a_lookup_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid && !out_en |=> s2_valid && $stable(trig))
      else $error("lookup stage overwritten while stalled");

endmodule
